// ===== rtl/atan2_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2_pkg
// Shared widths, Q30 constants and stage payload types of the arctangent unit.
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = 16;
  localparam int QBITS           = 30;
  localparam int SHIFT           = QBITS - ANGLE_FRAC_BITS;

  localparam int DW   = COORD_WIDTH + 1;   // ratio divisor, |x|+|y|
  localparam int ZW   = 29;                // reduced ratio z, Q30
  localparam int Z2W  = 28;                // z^2, Q30
  localparam int Z4W  = 26;                // z^4, Q30
  localparam int GW   = 34;                // Pade gap term
  localparam int GLW  = 17;                // low slice of gap per partial product
  localparam int GHW  = GW - GLW;
  localparam int DNW  = 37;                // Pade denominator
  localparam int QW   = 26;                // correction quotient
  localparam int PW   = 64;                // z*gap + den/2
  localparam int AW   = 32;                // angle magnitude, Q30

  localparam logic [31:0] TAN_HI       = 32'd2592242074;
  localparam logic [31:0] TAN_LO       = 32'd444758426;
  localparam logic [AW-1:0] PI_Q       = 32'd3373259426;
  localparam logic [AW-1:0] PI_HALF_Q  = 32'd1686629713;
  localparam logic [AW-1:0] PI_QUART_Q = 32'd843314857;

  localparam longint ANGLE_MAX = (longint'(PI_Q) + (longint'(1) << (SHIFT - 1))) >>> SHIFT;

  typedef enum logic [1:0] {
    REGION_LOW,
    REGION_MID,
    REGION_HIGH
  } region_t;

  typedef struct packed {
    logic    spec;       // an input is zero, angle is fixed
    logic    spec_half;  // fixed angle is pi/2
    region_t region;
    logic    sub;        // mid region with |y| < |x|
    logic    nx;
    logic    neg;
  } ctx_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [ZW-1:0] lo;
    ctx_t          ctx;
  } zdiv_t;

  typedef struct packed {
    logic [DNW-1:0] rem;
    logic [DNW-1:0] dvs;
    logic [QW-1:0]  lo;
    logic [ZW-1:0]  z;
    ctx_t           ctx;
  } qdiv_t;

endpackage

// ===== rtl/atan2_zdiv.sv =====
// ----------------------------------------------------------------------------
// atan2_zdiv
// Pipelined restoring divider for the reduced ratio, one quotient bit a stage.
// ----------------------------------------------------------------------------
module atan2_zdiv (
  input  logic                  clk,
  input  logic [atan2_pkg::ZW-1:0] en,
  input  atan2_pkg::zdiv_t      din,
  output atan2_pkg::zdiv_t      dout
);
  import atan2_pkg::*;

  zdiv_t st_r [ZW];

  for (genvar i = 0; i < ZW; i++) begin : g_step
    zdiv_t       cur;
    zdiv_t       st_nxt;
    logic [DW:0] t;
    logic        ge;

    if (i == 0) begin : g_first
      assign cur = din;
    end else begin : g_next
      assign cur = st_r[i-1];
    end

    assign t  = {cur.rem, cur.lo[ZW-1]};
    assign ge = t >= {1'b0, cur.dvs};

    always_comb begin
      st_nxt     = cur;
      st_nxt.rem = ge ? DW'(t - {1'b0, cur.dvs}) : t[DW-1:0];
      st_nxt.lo  = {cur.lo[ZW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  assign dout = st_r[ZW-1];

endmodule

// ===== rtl/two_argument_arctangent_unit.sv =====
// ----------------------------------------------------------------------------
// two_argument_arctangent_unit
// Four-quadrant arctangent of a signed coordinate pair by range reduction and
// a [5/4] Pade rational, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one (x, y) request per clock while in_tready is high and returns
// atan2(y, x) in radians, signed with 13 fractional bits, rounded to nearest.
// Between acceptance and out_tvalid lie two front stages, a 29-stage ratio divider,
// six multiply stages for the Pade terms, a 26-stage correction divider and
// three closing stages. Results leave in request order. Empty stages collapse
// while out_tready is low, so requests keep being accepted until every stage
// holds one.
module two_argument_arctangent_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [2*atan2_pkg::COORD_WIDTH-1:0] in_tdata,   // coord_x, coord_y
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [atan2_pkg::ANGLE_WIDTH-1:0] out_tdata    // angle
);
  import atan2_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int ST_Z0 = 2;
  localparam int ST_M  = ST_Z0 + ZW;
  localparam int ST_Q0 = ST_M + 6;
  localparam int ST_F  = ST_Q0 + QW;
  localparam int NST   = ST_F + 3;

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] rdy;

  always_comb begin
    logic [NST-1:0] low;
    for (int k = 0; k < NST; k++) begin
      low    = (NST'(1) << k) - NST'(1);
      rdy[k] = out_tready || ((v_r | low) != '1);
    end
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (!rdy[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 0) begin
        v_nxt[k] = in_tvalid;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NST-1];

  // stage 0: magnitudes
  logic [CW-1:0] cx, cy, ax_nxt, ay_nxt;
  logic [CW-1:0] ax0_r, ay0_r;
  logic          nx0_r, ny0_r;

  assign cx     = in_tdata[CW-1:0];
  assign cy     = in_tdata[2*CW-1:CW];
  assign ax_nxt = cx[CW-1] ? (~cx + CW'(1)) : cx;
  assign ay_nxt = cy[CW-1] ? (~cy + CW'(1)) : cy;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ax0_r <= ax_nxt;
      ay0_r <= ay_nxt;
      nx0_r <= cx[CW-1];
      ny0_r <= cy[CW-1];
    end
  end

  // stage 1: region, numerator and divisor
  logic [CW+QBITS-1:0] lhs;
  logic [CW+31:0]      rhs_hi, rhs_lo;
  logic [CW-1:0]       num;
  logic [DW-1:0]       dvs;
  logic [CW+QBITS-1:0] zdividend;
  zdiv_t               zin_nxt, zin_r, zout;
  logic                ax_zero, ay_zero;

  assign lhs     = {ay0_r, QBITS'(0)};
  assign rhs_hi  = (CW+32)'(ax0_r) * (CW+32)'(TAN_HI);
  assign rhs_lo  = (CW+32)'(ax0_r) * (CW+32)'(TAN_LO);
  assign ax_zero = ax0_r == '0;
  assign ay_zero = ay0_r == '0;

  always_comb begin
    zin_nxt = '0;
    if ({2'b0, lhs} > rhs_hi) begin
      zin_nxt.ctx.region = REGION_HIGH;
    end else if ({2'b0, lhs} > rhs_lo) begin
      zin_nxt.ctx.region = REGION_MID;
    end else begin
      zin_nxt.ctx.region = REGION_LOW;
    end
    zin_nxt.ctx.sub       = ay0_r < ax0_r;
    zin_nxt.ctx.spec      = ax_zero || ay_zero;
    zin_nxt.ctx.spec_half = ax_zero && !ay_zero;
    zin_nxt.ctx.nx        = ax_zero ? 1'b0 : nx0_r;
    zin_nxt.ctx.neg       = ay_zero ? 1'b0 : ny0_r;
    case (zin_nxt.ctx.region)
      REGION_HIGH: begin
        num = ax0_r;
        dvs = DW'(ay0_r);
      end
      REGION_MID: begin
        num = zin_nxt.ctx.sub ? (ax0_r - ay0_r) : (ay0_r - ax0_r);
        dvs = DW'(ay0_r) + DW'(ax0_r);
      end
      default: begin
        num = ay0_r;
        dvs = DW'(ax0_r);
      end
    endcase
    zdividend   = {num, QBITS'(dvs >> 1)};
    zin_nxt.rem = zdividend[ZW +: DW];
    zin_nxt.dvs = dvs;
    zin_nxt.lo  = zdividend[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      zin_r <= zin_nxt;
    end
  end

  atan2_zdiv u_zdiv (
    .clk  (clk),
    .en   (rdy[ST_Z0 +: ZW]),
    .din  (zin_r),
    .dout (zout)
  );

  // Pade terms
  logic [ZW-1:0]    z_a_r, z_b_r, z_c_r, z_d_r, z_e_r;
  ctx_t             ctx_a_r, ctx_b_r, ctx_c_r, ctx_d_r, ctx_e_r;
  logic [2*ZW-1:0]  z2p_r;
  logic [2*ZW:0]    z2_sum;
  logic [Z2W-1:0]   z2_b_r, z2_c_r;
  logic [2*Z2W-1:0] z4p_r;
  logic [2*Z2W:0]   z4_sum;
  logic [Z4W-1:0]   z4;
  logic [DNW-1:0]   den_d_r, den_e_r;
  logic [GW-1:0]    gap_d_r;
  logic [ZW+GLW-1:0] pl_r;
  logic [ZW+GHW-1:0] ph_r;
  logic [PW-1:0]    qdividend;
  qdiv_t            qin_nxt, qin_r;

  assign z2_sum = {1'b0, z2p_r} + ((2*ZW+1)'(1) << (QBITS - 1));
  assign z4_sum = {1'b0, z4p_r} + ((2*Z2W+1)'(1) << (QBITS - 1));
  assign z4     = z4_sum[QBITS +: Z4W];

  always_ff @(posedge clk) begin
    if (rdy[ST_M]) begin
      z_a_r   <= zout.lo;
      ctx_a_r <= zout.ctx;
      z2p_r   <= (2*ZW)'(zout.lo) * (2*ZW)'(zout.lo);
    end
    if (rdy[ST_M+1]) begin
      z_b_r   <= z_a_r;
      ctx_b_r <= ctx_a_r;
      z2_b_r  <= z2_sum[QBITS +: Z2W];
    end
    if (rdy[ST_M+2]) begin
      z_c_r   <= z_b_r;
      ctx_c_r <= ctx_b_r;
      z2_c_r  <= z2_b_r;
      z4p_r   <= (2*Z2W)'(z2_b_r) * (2*Z2W)'(z2_b_r);
    end
    if (rdy[ST_M+3]) begin
      z_d_r   <= z_c_r;
      ctx_d_r <= ctx_c_r;
      den_d_r <= (DNW'(105) << QBITS) + DNW'(45) * DNW'(z2_c_r) + DNW'(6) * DNW'(z4);
      gap_d_r <= GW'(35) * GW'(z2_c_r) + GW'(5) * GW'(z4);
    end
    if (rdy[ST_M+4]) begin
      z_e_r   <= z_d_r;
      ctx_e_r <= ctx_d_r;
      den_e_r <= den_d_r;
      pl_r    <= (ZW+GLW)'(z_d_r) * (ZW+GLW)'(gap_d_r[GLW-1:0]);
      ph_r    <= (ZW+GHW)'(z_d_r) * (ZW+GHW)'(gap_d_r[GW-1:GLW]);
    end
    if (rdy[ST_M+5]) begin
      qin_r <= qin_nxt;
    end
  end

  always_comb begin
    qdividend   = (PW'(ph_r) << GLW) + PW'(pl_r) + PW'(den_e_r >> 1);
    qin_nxt.rem = qdividend[QW +: DNW];
    qin_nxt.dvs = den_e_r;
    qin_nxt.lo  = qdividend[QW-1:0];
    qin_nxt.z   = z_e_r;
    qin_nxt.ctx = ctx_e_r;
  end

  // correction divider
  qdiv_t qst_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_qdiv
    qdiv_t        cur;
    qdiv_t        st_nxt;
    logic [DNW:0] t;
    logic         ge;

    if (i == 0) begin : g_first
      assign cur = qin_r;
    end else begin : g_next
      assign cur = qst_r[i-1];
    end

    assign t  = {cur.rem, cur.lo[QW-1]};
    assign ge = t >= {1'b0, cur.dvs};

    always_comb begin
      st_nxt     = cur;
      st_nxt.rem = ge ? DNW'(t - {1'b0, cur.dvs}) : t[DNW-1:0];
      st_nxt.lo  = {cur.lo[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_Q0+i]) begin
        qst_r[i] <= st_nxt;
      end
    end
  end

  // closing stages
  qdiv_t         qlast;
  logic [ZW-1:0] p;
  logic [AW-1:0] a_nxt, a_r, a_c, mag_r;
  ctx_t          ctx_f_r;
  logic          neg_g_r;
  logic [AW:0]   rsum;
  logic [AW-SHIFT:0] rmag;
  logic [ANGLE_WIDTH-1:0] out_r;

  assign qlast = qst_r[QW-1];

  always_comb begin
    p = ({3'b0, qlast.lo} <= qlast.z) ? (qlast.z - ZW'(qlast.lo)) : '0;
    case (qlast.ctx.region)
      REGION_HIGH: a_nxt = PI_HALF_Q - AW'(p);
      REGION_MID: begin
        if (!qlast.ctx.sub) begin
          a_nxt = PI_QUART_Q + AW'(p);
        end else begin
          a_nxt = (AW'(p) <= PI_QUART_Q) ? (PI_QUART_Q - AW'(p)) : '0;
        end
      end
      default: a_nxt = AW'(p);
    endcase
  end

  always_comb begin
    if (ctx_f_r.spec) begin
      a_c = ctx_f_r.spec_half ? PI_HALF_Q : '0;
    end else begin
      a_c = (a_r > PI_HALF_Q) ? PI_HALF_Q : a_r;
    end
  end

  assign rsum = {1'b0, mag_r} + ((AW+1)'(1) << (SHIFT - 1));
  assign rmag = rsum[AW:SHIFT];

  always_ff @(posedge clk) begin
    if (rdy[ST_F]) begin
      a_r     <= a_nxt;
      ctx_f_r <= qlast.ctx;
    end
    if (rdy[ST_F+1]) begin
      mag_r   <= ctx_f_r.nx ? (PI_Q - a_c) : a_c;
      neg_g_r <= ctx_f_r.neg;
    end
    if (rdy[ST_F+2]) begin
      out_r <= neg_g_r ? ANGLE_WIDTH'(-rmag) : ANGLE_WIDTH'(rmag);
    end
  end

  assign out_tdata = out_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= $signed(ANGLE_WIDTH'(ANGLE_MAX))) &&
                   ($signed(out_tdata) >= -$signed(ANGLE_WIDTH'(ANGLE_MAX))))
    else $error("angle out of range");

  a_room_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r != '1) |-> in_tready)
    else $error("request refused with an empty stage");

  a_corr_below_z: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ST_F-1] && !qlast.ctx.spec) |-> ({3'b0, qlast.lo} <= qlast.z))
    else $error("Pade correction exceeds ratio");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && v_r == $past(v_r)) || (v_r != $past(v_r)))
    else $error("result lost under stall");

endmodule

// ===== verif/tb_two_argument_arctangent_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_argument_arctangent_unit
// Self-checking bench for the four-quadrant arctangent unit. Drives the zero
// and axis cases, octant boundaries and extreme coordinates from a table,
// then random pairs. Both stream sides idle at random, with one back-to-back burst.
// Each angle is checked against its fixed table value or a Q30 predictor.
// ----------------------------------------------------------------------------
module tb_two_argument_arctangent_unit;
  import atan2_pkg::*;

  localparam int N_RANDOM    = 1750;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               fixed;
    logic [15:0]        angle;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  logic [15:0] angle_q[$];
  int          n_req;
  int          n_resp;
  int          n_err;
  int          cycles;
  bit          burst;
  bit          done;

  two_argument_arctangent_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] pade_q30(logic [63:0] n, logic [63:0] d);
    logic [63:0] z, z2, z4, den, gap, q;
    if (d == 0) return 0;
    z   = ((n << 30) + (d >> 1)) / d;
    z2  = (z * z + (64'd1 << 29)) >> 30;
    z4  = (z2 * z2 + (64'd1 << 29)) >> 30;
    den = 64'd105 * (64'd1 << 30) + 64'd45 * z2 + 64'd6 * z4;
    gap = 64'd35 * z2 + 64'd5 * z4;
    q   = (z * gap + (den >> 1)) / den;
    return (q <= z) ? z - q : 0;
  endfunction

  function automatic logic [15:0] atan2_angle(logic [15:0] xr, logic [15:0] yr);
    logic [63:0] ax, ay, mag, a, p, r, lhs;
    logic        nx, ny, neg;
    nx  = xr[15];
    ny  = yr[15];
    ax  = nx ? 64'h10000 - xr : 64'(xr);
    ay  = ny ? 64'h10000 - yr : 64'(yr);
    neg = ny;
    if (ax == 0 && ay == 0) begin
      mag = 0;
      neg = 1'b0;
    end else if (ax == 0) begin
      mag = PI_HALF_Q;
    end else if (ay == 0) begin
      mag = nx ? 64'(PI_Q) : 0;
      neg = 1'b0;
    end else begin
      lhs = ay << 30;
      if (lhs > ax * TAN_HI) begin
        p = pade_q30(ax, ay);
        a = PI_HALF_Q - p;
      end else if (lhs > ax * TAN_LO) begin
        if (ay >= ax) begin
          a = PI_QUART_Q + pade_q30(ay - ax, ay + ax);
        end else begin
          p = pade_q30(ax - ay, ay + ax);
          a = (p <= PI_QUART_Q) ? PI_QUART_Q - p : 0;
        end
      end else begin
        a = pade_q30(ay, ax);
      end
      if (a > PI_HALF_Q) a = PI_HALF_Q;
      mag = nx ? PI_Q - a : a;
    end
    r = (mag + (64'd1 << (SHIFT - 1))) >> SHIFT;
    return neg ? 16'(-r) : 16'(r);
  endfunction

  task automatic send_coords(logic [15:0] x, logic [15:0] y);
    while (!burst && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    n_req++;
    angle_q.push_back(atan2_angle(x, y));
  endtask

  task automatic send_fixed(dir_row_t row);
    logic [15:0] pred;
    pred = atan2_angle(row.x, row.y);
    if (row.fixed && pred != row.angle)
      $display("note: table angle %0d differs from predictor %0d", row.angle, pred);
    send_coords(row.x, row.y);
    if (row.fixed) angle_q[$] = row.angle;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_resp++;
      if (angle_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("error: unexpected angle %0d", $signed(out_tdata));
      end else begin
        if (out_tdata !== angle_q[0]) begin
          n_err++;
          if (n_err <= 10)
            $display("error: angle exp %0d got %0d", $signed(angle_q[0]),
                     $signed(out_tdata));
        end
        void'(angle_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= (burst || !rst_n) ? 1'b1 : ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT && !done) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int       mode;
    logic [15:0] x, y;
    dir_rows = '{
      '{16'sd0, 16'sd0, 1'b1, 16'd0},
      '{16'sd0, 16'sd1, 1'b1, 16'd12868},
      '{16'sd0, -16'sd1, 1'b1, 16'hCDBC},
      '{16'sd5, 16'sd0, 1'b1, 16'd0},
      '{-16'sd5, 16'sd0, 1'b1, 16'd25736},
      '{-16'sd32768, 16'sd0, 1'b1, 16'd25736},
      '{16'sd0, -16'sd32768, 1'b1, 16'hCDBC},
      '{16'sd32767, 16'sd32767, 1'b0, 16'd0},
      '{-16'sd32768, -16'sd32768, 1'b0, 16'd0},
      '{-16'sd32768, 16'sd32767, 1'b0, 16'd0},
      '{16'sd32767, -16'sd32768, 1'b0, 16'd0},
      '{16'sd32767, 16'sd1, 1'b0, 16'd0},
      '{16'sd1, 16'sd32767, 1'b0, 16'd0},
      '{-16'sd1, -16'sd32767, 1'b0, 16'd0},
      '{16'sd1, -16'sd1, 1'b0, 16'd0},
      '{-16'sd1, 16'sd1, 1'b0, 16'd0},
      '{16'sd10000, 16'sd4142, 1'b0, 16'd0},
      '{16'sd10000, 16'sd4143, 1'b0, 16'd0},
      '{16'sd10000, 16'sd24142, 1'b0, 16'd0},
      '{16'sd10000, 16'sd24143, 1'b0, 16'd0},
      '{-16'sd10000, -16'sd24143, 1'b0, 16'd0},
      '{16'sd3, 16'sd2, 1'b0, 16'd0},
      '{-16'sd2, 16'sd3, 1'b0, 16'd0}
    };
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    n_req = 0; n_resp = 0; n_err = 0; cycles = 0;
    burst = 1'b0; done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_fixed(dir_rows[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      burst = (i >= 600 && i < 900);
      mode = $urandom_range(9);
      x = 16'($urandom);
      y = 16'($urandom);
      if (mode == 0) begin
        x = 16'($urandom_range(15)) - 16'd8;
        y = 16'($urandom_range(15)) - 16'd8;
      end else if (mode == 1) begin
        if ($urandom_range(1)) x = 0; else y = 0;
      end else if (mode == 2) begin
        y = ($urandom_range(1) ? x : -x) + 16'($urandom_range(4)) - 16'd2;
      end else if (mode == 3) begin
        x = {x[15], 15'h7FF0 | x[3:0]};
      end
      send_coords(x, y);
    end
    burst = 1'b0;
    in_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    done = 1'b1;
    $display("sent %0d coordinate pairs, checked %0d angles, %0d mismatches",
             n_req, n_resp, n_err);
    if (n_err == 0 && angle_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/atan2_pkg.sv
rtl/atan2_zdiv.sv
rtl/two_argument_arctangent_unit.sv
verif/tb_two_argument_arctangent_unit.sv
